@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the escape decoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ sv/qsed_pkg.sv @@
// ----------------------------------------------------------------------------
// qsed_pkg
// types, codes and character helpers for the quoted string escape decoder
// ----------------------------------------------------------------------------
package qsed_pkg;

    typedef enum logic [2:0] {
        PH_OPEN = 3'd0,
        PH_BODY = 3'd1,
        PH_ESC  = 3'd2,
        PH_OCT  = 3'd3,
        PH_HEX  = 3'd4
    } phase_t;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_NOT_QUOTED    = 3'd1;
    localparam logic [2:0] ST_UNKNOWN_ESC   = 3'd2;
    localparam logic [2:0] ST_OCT_RANGE     = 3'd3;
    localparam logic [2:0] ST_HEX_NO_DIGITS = 3'd4;
    localparam logic [2:0] ST_HEX_RANGE     = 3'd5;

    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LOWER_E = 8'h65;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam logic [7:0] CODE_ESC = 8'h1B;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic [2:0] status;
    } res_t;

    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } push_t;

    function automatic logic is_quote(input logic [7:0] b);
        is_quote = (b == CH_SQUOTE) || (b == CH_DQUOTE);
    endfunction

    function automatic logic is_oct_digit(input logic [7:0] b);
        is_oct_digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic logic is_hex_digit(input logic [7:0] b);
        is_hex_digit = ((b >= CH_ZERO) && (b <= CH_NINE))
                    || ((b >= CH_LOWER_A) && (b <= CH_LOWER_F))
                    || ((b >= CH_UPPER_A) && (b <= CH_UPPER_F));
    endfunction

    // letters a-f and A-F share the low nibble 1..6
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        if (b <= CH_NINE)
        begin
            hex_value = b[3:0];
        end
        else
        begin
            hex_value = b[3:0] + 4'd9;
        end
    endfunction

endpackage

@@ sv/qsed_decode.sv @@
// ----------------------------------------------------------------------------
// qsed_decode
// literal state and single pass decode of one held byte into up to two results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qsed_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         in_data,
    input  logic               in_last,
    output qsed_pkg::push_t    push
);

    qsed_pkg::phase_t phase_reg, phase_next;
    logic [7:0] open_quote_reg, open_quote_next;
    logic [7:0] escape_value_reg, escape_value_next;
    logic       value_overflow_reg, value_overflow_next;
    logic       digit_seen_reg, digit_seen_next;
    logic [2:0] first_error_reg, first_error_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= qsed_pkg::PH_OPEN;
            open_quote_reg     <= '0;
            escape_value_reg   <= '0;
            value_overflow_reg <= 1'b0;
            digit_seen_reg     <= 1'b0;
            first_error_reg    <= qsed_pkg::ST_OK;
        end
        else
        begin
            phase_reg          <= phase_next;
            open_quote_reg     <= open_quote_next;
            escape_value_reg   <= escape_value_next;
            value_overflow_reg <= value_overflow_next;
            digit_seen_reg     <= digit_seen_next;
            first_error_reg    <= first_error_next;
        end
    end

    always_comb
    begin
        qsed_pkg::phase_t ph;
        logic [2:0]  err;
        logic        done;
        logic        dig_ok;
        logic [3:0]  dig;
        logic [11:0] acc;
        logic        va;
        logic        vb;
        qsed_pkg::res_t ra;
        qsed_pkg::res_t rb;

        phase_next          = phase_reg;
        open_quote_next     = open_quote_reg;
        escape_value_next   = escape_value_reg;
        value_overflow_next = value_overflow_reg;
        digit_seen_next     = digit_seen_reg;
        first_error_next    = first_error_reg;

        ph     = phase_reg;
        err    = first_error_reg;
        done   = 1'b0;
        dig_ok = 1'b0;
        dig    = '0;
        acc    = '0;
        va     = 1'b0;
        vb     = 1'b0;
        ra     = '{data: escape_value_reg, eos: 1'b0, status: qsed_pkg::ST_OK};
        rb     = '{data: in_data, eos: 1'b0, status: qsed_pkg::ST_OK};

        if (fire)
        begin
            if (phase_reg == qsed_pkg::PH_OPEN)
            begin
                open_quote_next = in_data;
                phase_next      = qsed_pkg::PH_BODY;
                if (!qsed_pkg::is_quote(in_data))
                begin
                    first_error_next = qsed_pkg::ST_NOT_QUOTED;
                end
                if (in_last)
                begin
                    vb = 1'b1;
                    rb = '{data: 8'd0, eos: 1'b1, status: qsed_pkg::ST_NOT_QUOTED};
                    phase_next          = qsed_pkg::PH_OPEN;
                    open_quote_next     = '0;
                    escape_value_next   = '0;
                    value_overflow_next = 1'b0;
                    digit_seen_next     = 1'b0;
                    first_error_next    = qsed_pkg::ST_OK;
                end
            end
            else
            begin
                // open numeric escape: take a digit or terminate
                if (ph == qsed_pkg::PH_OCT || ph == qsed_pkg::PH_HEX)
                begin
                    if (ph == qsed_pkg::PH_OCT)
                    begin
                        dig_ok = qsed_pkg::is_oct_digit(in_data);
                        dig    = {1'b0, in_data[2:0]};
                        acc    = {1'b0, escape_value_reg, 3'b000} + {8'd0, dig};
                    end
                    else
                    begin
                        dig_ok = qsed_pkg::is_hex_digit(in_data);
                        dig    = qsed_pkg::hex_value(in_data);
                        acc    = {escape_value_reg, 4'b0000} + {8'd0, dig};
                    end
                    if (dig_ok && !in_last)
                    begin
                        escape_value_next   = acc[7:0];
                        value_overflow_next = value_overflow_reg | (acc[11:8] != 4'd0);
                        digit_seen_next     = 1'b1;
                        done                = 1'b1;
                    end
                    else
                    begin
                        if (ph == qsed_pkg::PH_HEX && !digit_seen_reg)
                        begin
                            err = qsed_pkg::ST_HEX_NO_DIGITS;
                        end
                        else if (value_overflow_reg)
                        begin
                            err = (ph == qsed_pkg::PH_OCT) ? qsed_pkg::ST_OCT_RANGE
                                                           : qsed_pkg::ST_HEX_RANGE;
                        end
                        else
                        begin
                            va = 1'b1;
                        end
                        ph = qsed_pkg::PH_BODY;
                    end
                end

                if (!done)
                begin
                    if (in_last)
                    begin
                        if (err == qsed_pkg::ST_OK && ph == qsed_pkg::PH_ESC)
                        begin
                            err = qsed_pkg::ST_UNKNOWN_ESC;
                        end
                        vb = 1'b1;
                        rb.data = 8'd0;
                        rb.eos  = 1'b1;
                        if (qsed_pkg::is_quote(open_quote_reg) && in_data == open_quote_reg)
                        begin
                            rb.status = err;
                        end
                        else
                        begin
                            rb.status = qsed_pkg::ST_NOT_QUOTED;
                        end
                        phase_next          = qsed_pkg::PH_OPEN;
                        open_quote_next     = '0;
                        escape_value_next   = '0;
                        value_overflow_next = 1'b0;
                        digit_seen_next     = 1'b0;
                        first_error_next    = qsed_pkg::ST_OK;
                    end
                    else
                    begin
                        if (err != qsed_pkg::ST_OK)
                        begin
                            // bytes after an error are dropped
                        end
                        else if (ph == qsed_pkg::PH_ESC)
                        begin
                            ph = qsed_pkg::PH_BODY;
                            case (in_data)
                                qsed_pkg::CH_LOWER_E:
                                begin
                                    vb = 1'b1;
                                    rb.data = qsed_pkg::CODE_ESC;
                                end
                                qsed_pkg::CH_LOWER_N:
                                begin
                                    vb = 1'b1;
                                    rb.data = qsed_pkg::CODE_LF;
                                end
                                qsed_pkg::CH_LOWER_R:
                                begin
                                    vb = 1'b1;
                                    rb.data = qsed_pkg::CODE_CR;
                                end
                                qsed_pkg::CH_BSLASH,
                                qsed_pkg::CH_SQUOTE,
                                qsed_pkg::CH_DQUOTE:
                                begin
                                    vb = 1'b1;
                                end
                                qsed_pkg::CH_LOWER_X:
                                begin
                                    escape_value_next   = '0;
                                    value_overflow_next = 1'b0;
                                    digit_seen_next     = 1'b0;
                                    ph                  = qsed_pkg::PH_HEX;
                                end
                                default:
                                begin
                                    if (qsed_pkg::is_oct_digit(in_data))
                                    begin
                                        escape_value_next   = {5'd0, in_data[2:0]};
                                        value_overflow_next = 1'b0;
                                        digit_seen_next     = 1'b1;
                                        ph                  = qsed_pkg::PH_OCT;
                                    end
                                    else
                                    begin
                                        err = qsed_pkg::ST_UNKNOWN_ESC;
                                    end
                                end
                            endcase
                        end
                        else if (in_data == qsed_pkg::CH_BSLASH)
                        begin
                            ph = qsed_pkg::PH_ESC;
                        end
                        else
                        begin
                            vb = 1'b1;
                        end
                        phase_next       = ph;
                        first_error_next = err;
                    end
                end
            end
        end

        // pack results so that slot 0 is filled first
        push.v0 = va | vb;
        push.v1 = va & vb;
        push.r0 = va ? ra : rb;
        push.r1 = rb;
    end

    `ASSERT_CLK(a_end_resets_phase, clk, rst_n,
        fire && ((push.v0 && push.r0.eos) || (push.v1 && push.r1.eos))
        |=> phase_reg == qsed_pkg::PH_OPEN,
        "end beat did not return decoder to opening quote")
    `ASSERT_CLK(a_data_without_error, clk, rst_n,
        push.v0 && !push.r0.eos |-> first_error_reg == qsed_pkg::ST_OK,
        "data beat emitted after an error")
    `ASSERT_CLK(a_pair_from_numeric, clk, rst_n,
        push.v1 |-> (phase_reg == qsed_pkg::PH_OCT || phase_reg == qsed_pkg::PH_HEX),
        "two results without a numeric escape being closed")

endmodule

@@ sv/qsed_out_queue.sv @@
// ----------------------------------------------------------------------------
// qsed_out_queue
// small result queue taking up to two beats a cycle and giving one while out_ready is high
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qsed_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  qsed_pkg::push_t    push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output qsed_pkg::res_t     out_res
);

    localparam int AW = qsed_pkg::QUEUE_AW;

    qsed_pkg::res_t mem_reg [qsed_pkg::QUEUE_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic [AW-1:0] wr_ptr_inc;
    logic [1:0]    push_n;
    logic          pop;

    assign wr_ptr_inc = wr_ptr_reg + AW'(1);
    assign push_n     = {1'b0, push.v0} + {1'b0, push.v1};
    assign pop        = out_valid && out_ready;
    assign out_valid  = count_reg != '0;
    assign out_res    = mem_reg[rd_ptr_reg];
    assign room       = count_reg <= (AW+1)'(qsed_pkg::QUEUE_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + (AW+1)'(push_n) - (AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_inc] <= push.r1;
        end
    end

    `ASSERT_CLK(a_ptr_count_match, clk, rst_n,
        AW'(wr_ptr_reg - rd_ptr_reg) == count_reg[AW-1:0],
        "queue pointers disagree with fill count")
    `ASSERT_NEVER(a_push_without_room, clk, rst_n,
        push.v0 && !room,
        "result pushed into queue without room for a pair")
    `ASSERT_NEVER(a_count_over_depth, clk, rst_n,
        count_reg > (AW+1)'(qsed_pkg::QUEUE_DEPTH),
        "queue fill count beyond depth")

endmodule

@@ sv/quoted_string_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder
// decodes the escapes of one quoted literal per frame and closes each frame
// with a status beat
//
//   channel   dir   beat payload
//   s_axis    in    tdata = in_byte, tlast = is_last
//   m_axis    out   tdata = out_byte, tlast = end_of_string, tuser = status
//
// one input beat per cycle while the queue has room; each taken beat is held in an input register
// and decoded from there into the result queue, which feeds m_axis
// a numeric escape closed by the next byte can give two output beats for that byte
// the four entry result queue lets s_axis run on while m_axis stalls; s_axis
// stalls once more than two results wait
// reset returns the decoder to awaiting an opening quote and empties the queue
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [2:0] m_axis_tuser    // [2:0] status
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       room;
    logic       fire;
    logic       s_accept;

    qsed_pkg::push_t push;
    qsed_pkg::res_t  out_res;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    qsed_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_data (in_data_reg),
        .in_last (in_last_reg),
        .push    (push)
    );

    qsed_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.data;
    assign m_axis_tlast = out_res.eos;
    assign m_axis_tuser = out_res.status;

endmodule
